>>> rtl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_MIXED = 3'd3,
    OP_GCD   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_REDUCE = 2'd0,
    KIND_MIXED  = 2'd1,
    KIND_GCD    = 2'd2,
    KIND_ZERO   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_MOD_WAIT,
    ST_DIVN,
    ST_DIVN_WAIT,
    ST_DIVD,
    ST_DIVD_WAIT,
    ST_DONE
  } be_state_t;

  localparam int unsigned QDEPTH = 2;

endpackage

>>> rtl/rational_arithmetic_unit_top.sv
// top level of the rational arithmetic unit
`timescale 1ns / 1ps
// Adds, subtracts or multiplies two signed fractions and reduces the result by a
// Euclidean gcd, splits a fraction into whole part and remainder, or returns the
// signed gcd of two numerators. The front end registers the cross products and
// parks them in a two-entry queue; the back end runs every remainder
// and reduction division on one shared restoring divider of 2*OPERAND_WIDTH+2
// bits, one quotient bit a cycle. Each euclid step is one division, and a
// reduction adds two more divisions. A finished result waits in an output
// register while the next item starts.
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [2:0]                      in_operation,
  input  logic signed [OPERAND_WIDTH-1:0] in_first_numerator,
  input  logic signed [OPERAND_WIDTH-1:0] in_first_denominator,
  input  logic signed [OPERAND_WIDTH-1:0] in_second_numerator,
  input  logic signed [OPERAND_WIDTH-1:0] in_second_denominator,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic signed [2*OPERAND_WIDTH-1:0] out_result_numerator,
  output logic signed [2*OPERAND_WIDTH-2:0] out_result_denominator,
  output logic signed [OPERAND_WIDTH-1:0]   out_whole_number
);

  logic in_ready, q_valid, q_pop;
  kind_t q_kind;
  logic signed [2*OPERAND_WIDTH+1:0] q_num, q_den;

  assign in_full = !in_ready;

  rau_front #(.OW(OPERAND_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_push),
    .in_ready(in_ready),
    .op      (in_operation),
    .an      (in_first_numerator),
    .ad      (in_first_denominator),
    .bn      (in_second_numerator),
    .bd      (in_second_denominator),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_kind  (q_kind),
    .q_num   (q_num),
    .q_den   (q_den)
  );

  rau_back #(.OW(OPERAND_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_kind   (q_kind),
    .q_num    (q_num),
    .q_den    (q_den),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_num  (out_result_numerator),
    .out_den  (out_result_denominator),
    .out_whole(out_whole_number)
  );

endmodule

>>> rtl/rau_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
module rau_div
  import rau_pkg::*;
#(
  parameter int unsigned W = 34
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic signed [W-1:0] divisor,
  output logic                done,
  output logic signed [W-1:0] quotient,
  output logic signed [W-1:0] remainder
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic          qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    trial;
  logic [W-1:0]  shifted;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[W-2:0], quo_r[W-1]};
    trial    = {1'b0, shifted} - {1'b0, dsr_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend[W-1] ? W'(-dividend) : dividend;
      dsr_nxt  = divisor[W-1] ? W'(-divisor) : divisor;
      qneg_nxt = dividend[W-1] ^ divisor[W-1];
      rneg_nxt = dividend[W-1];
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step
      if (!trial[W] || rem_r[W-1]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dsr_r  <= dsr_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign done      = done_r;
  assign quotient  = qneg_r ? W'(-quo_r) : quo_r;
  assign remainder = rneg_r ? W'(-rem_r) : rem_r;

endmodule

>>> rtl/rau_front.sv
// front end: decode operation and form products into a short queue
`timescale 1ns / 1ps
module rau_front
  import rau_pkg::*;
#(
  parameter int unsigned OW = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             op,
  input  logic signed [OW-1:0]   an,
  input  logic signed [OW-1:0]   ad,
  input  logic signed [OW-1:0]   bn,
  input  logic signed [OW-1:0]   bd,
  output logic                   q_valid,
  input  logic                   q_pop,
  output kind_t                  q_kind,
  output logic signed [2*OW+1:0] q_num,
  output logic signed [2*OW+1:0] q_den
);

  localparam int unsigned XW = 2 * OW + 2;
  localparam int unsigned PW = $clog2(QDEPTH);

  // stage 1: products registered
  logic                  s1_v_r;
  kind_t                 s1_kind_r, kind_c;
  logic signed [2*OW-1:0] p1_r, p2_r, p3_r;
  logic signed [OW-1:0]  an_r, ad_r;
  logic signed [OW:0]    bn_x;

  kind_t         qk_r [QDEPTH];
  logic [XW-1:0] qn_r [QDEPTH];
  logic [XW-1:0] qd_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push_q;
  logic signed [XW-1:0] num_c, den_c;

  assign bn_x = (op == OP_SUB) ? -(OW + 1)'(bn) : (OW + 1)'(bn);

  always_comb begin
    case (op)
      OP_ADD, OP_SUB, OP_MUL: kind_c = KIND_REDUCE;
      OP_MIXED:               kind_c = KIND_MIXED;
      OP_GCD:                 kind_c = KIND_GCD;
      default:                kind_c = KIND_ZERO;
    endcase
  end

  // stage 1 holds one item; accept only when queue has room for it
  assign in_ready = !s1_v_r && (cnt_r < (PW + 1)'(QDEPTH));
  assign push_q   = s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid && in_ready;
    end
    if (in_valid && in_ready) begin
      s1_kind_r <= kind_c;
      if (op == OP_MUL) begin
        p1_r <= an * bn;
        p2_r <= '0;
      end else if (kind_c == KIND_GCD) begin
        p1_r <= '0;
        p2_r <= (2*OW)'(bn);
      end else begin
        p1_r <= (2*OW)'(an * bd);
        p2_r <= (2*OW)'(bn_x * ad);
      end
      p3_r <= ad * bd;
      an_r <= an;
      ad_r <= ad;
    end
  end

  always_comb begin
    num_c = '0;
    den_c = '0;
    case (s1_kind_r)
      KIND_REDUCE: begin
        num_c = XW'(p1_r) + XW'(p2_r);
        den_c = XW'(p3_r);
      end
      KIND_MIXED: begin
        num_c = XW'(an_r);
        den_c = XW'(ad_r);
      end
      KIND_GCD: begin
        num_c = XW'(an_r);
        den_c = XW'(p2_r);
      end
      default: begin
        num_c = '0;
        den_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_q) wp_r <= wp_r + 1'b1;
      if (q_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW + 1)'(push_q) - (PW + 1)'(q_pop);
    end
    if (push_q) begin
      qk_r[wp_r] <= s1_kind_r;
      qn_r[wp_r] <= num_c;
      qd_r[wp_r] <= den_c;
    end
  end

  assign q_valid = cnt_r != '0;
  assign q_kind  = qk_r[rp_r];
  assign q_num   = qn_r[rp_r];
  assign q_den   = qd_r[rp_r];

endmodule

>>> rtl/rau_back.sv
// back end: euclid gcd, reduction and mixed split on one shared divider
`timescale 1ns / 1ps
module rau_back
  import rau_pkg::*;
#(
  parameter int unsigned OW = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  kind_t                  q_kind,
  input  logic signed [2*OW+1:0] q_num,
  input  logic signed [2*OW+1:0] q_den,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic signed [2*OW-1:0] out_num,
  output logic signed [2*OW-2:0] out_den,
  output logic signed [OW-1:0]   out_whole
);

  localparam int unsigned XW = 2 * OW + 2;

  be_state_t st_r, st_nxt;
  kind_t     kind_r, kind_nxt;
  logic signed [XW-1:0] n_r, n_nxt, d_r, d_nxt;
  logic signed [XW-1:0] big_r, big_nxt, sml_r, sml_nxt, g_r, g_nxt;
  logic signed [2*OW-1:0] on_r, on_nxt;
  logic signed [2*OW-2:0] od_r, od_nxt;
  logic signed [OW-1:0]   ow_r, ow_nxt;
  logic                   full_r, full_nxt;
  logic                   dv_start;
  logic signed [XW-1:0]   dv_a, dv_b, dv_q, dv_r;
  logic                   dv_done;

  rau_div #(.W(XW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_a),
    .divisor  (dv_b),
    .done     (dv_done),
    .quotient (dv_q),
    .remainder(dv_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      full_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      full_r <= full_nxt;
    end
    kind_r <= kind_nxt;
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    big_r  <= big_nxt;
    sml_r  <= sml_nxt;
    g_r    <= g_nxt;
    on_r   <= on_nxt;
    od_r   <= od_nxt;
    ow_r   <= ow_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    kind_nxt = kind_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    big_nxt  = big_r;
    sml_nxt  = sml_r;
    g_nxt    = g_r;
    on_nxt   = on_r;
    od_nxt   = od_r;
    ow_nxt   = ow_r;
    full_nxt = full_r && !out_pop;
    q_pop    = 1'b0;
    dv_start = 1'b0;
    dv_a     = big_r;
    dv_b     = sml_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          kind_nxt = q_kind;
          n_nxt    = q_num;
          d_nxt    = q_den;
          if (q_kind == KIND_MIXED) begin
            big_nxt = q_num;
            sml_nxt = q_den;
            st_nxt  = (q_den == '0) ? ST_DONE : ST_MOD;
          end else if (q_kind == KIND_ZERO) begin
            st_nxt = ST_DONE;
          end else if (q_num == '0 || q_den == '0) begin
            // gcd is the other operand
            g_nxt  = (q_num == '0) ? q_den : q_num;
            st_nxt = (q_kind == KIND_REDUCE) ? ST_DIVN : ST_DONE;
          end else begin
            big_nxt = (q_num > q_den) ? q_num : q_den;
            sml_nxt = (q_num > q_den) ? q_den : q_num;
            st_nxt  = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        dv_start = 1'b1;
        st_nxt   = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (dv_done) begin
          if (kind_r == KIND_MIXED) begin
            st_nxt = ST_DONE;
          end else if (dv_r == '0) begin
            g_nxt  = sml_r;
            st_nxt = (kind_r == KIND_REDUCE) ? ST_DIVN : ST_DONE;
          end else begin
            big_nxt = sml_r;
            sml_nxt = dv_r;
            st_nxt  = ST_MOD;
          end
        end
      end
      ST_DIVN: begin
        if (g_r == '0) begin
          st_nxt = ST_DONE;
        end else begin
          dv_a     = n_r;
          dv_b     = g_r[XW-1] ? -g_r : g_r;
          dv_start = 1'b1;
          st_nxt   = ST_DIVN_WAIT;
        end
      end
      ST_DIVN_WAIT: begin
        if (dv_done) begin
          n_nxt  = dv_q;
          st_nxt = ST_DIVD;
        end
      end
      ST_DIVD: begin
        dv_a     = d_r;
        dv_b     = g_r[XW-1] ? -g_r : g_r;
        dv_start = 1'b1;
        st_nxt   = ST_DIVD_WAIT;
      end
      ST_DIVD_WAIT: begin
        if (dv_done) begin
          d_nxt  = dv_q;
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!full_r || out_pop) begin
          full_nxt = 1'b1;
          on_nxt   = '0;
          od_nxt   = '0;
          ow_nxt   = '0;
          case (kind_r)
            KIND_REDUCE: begin
              on_nxt = n_r[2*OW-1:0];
              od_nxt = d_r[2*OW-2:0];
            end
            KIND_MIXED: begin
              od_nxt = d_r[2*OW-2:0];
              if (d_r != '0) begin
                on_nxt = dv_r[2*OW-1:0];
                ow_nxt = dv_q[OW-1:0];
              end
            end
            KIND_GCD: on_nxt = g_r[2*OW-1:0];
            default: ;
          endcase
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_empty = !full_r;
  assign out_num   = on_r;
  assign out_den   = od_r;
  assign out_whole = ow_r;

endmodule
